@@ src/ssgp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssgp_pkg
// Shared types and constants for the swipe sensor gain / presence block.
// ----------------------------------------------------------------------------
package ssgp_pkg;

  localparam int NUM_BINS_DEFAULT = 16;

  localparam int SUM_W   = 20;
  localparam int GAIN_W  = 8;
  localparam int CNT_W   = 4;
  localparam int DET_W   = 8;
  localparam int ADDR_W  = 3;
  localparam int CDATA_W = 20;

  localparam logic [7:0]        MARKER_OK = 8'hDE;
  localparam logic [GAIN_W-1:0] GAIN_STEP = 8'h08;
  localparam logic [SUM_W-1:0]  SUM_MAX   = 20'hFFFFF;
  localparam logic [DET_W-1:0]  DET_MAX   = 8'hFF;
  localparam logic [CNT_W-1:0]  EMPTY_MAX = 4'hF;

  // register reset values
  localparam logic [SUM_W-1:0]  SUM_LOW_RST    = 20'd700;
  localparam logic [SUM_W-1:0]  SUM_HIGH_RST   = 20'd1000;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR_RST = 8'd40;
  localparam logic [GAIN_W-1:0] GAIN_CEIL_RST  = 8'd88;
  localparam logic [7:0]        PRESENCE_RST   = 8'd20;
  localparam logic [CNT_W-1:0]  EMPTY_LIM_RST  = 4'd3;

  typedef enum logic [ADDR_W-1:0] {
    REG_SUM_LOW   = 3'd0,
    REG_SUM_HIGH  = 3'd1,
    REG_GAIN_FLR  = 3'd2,
    REG_GAIN_CEIL = 3'd3,
    REG_PRESENCE  = 3'd4,
    REG_EMPTY_LIM = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_BIN    = 2'd1,
    FUNC_DETECT = 2'd2
  } func_e;

  localparam logic KIND_STRIP  = 1'b0;
  localparam logic KIND_FINGER = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0]  sum_low_limit;
    logic [SUM_W-1:0]  sum_high_limit;
    logic [GAIN_W-1:0] gain_floor;
    logic [GAIN_W-1:0] gain_ceiling;
    logic [7:0]        presence_level;
    logic [CNT_W-1:0]  empty_limit;
  } cfg_t;

endpackage

@@ src/ssgp_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssgp_cfg_regs
// Configuration register file; decodes writes and holds the limits.
// ----------------------------------------------------------------------------
module ssgp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ssgp_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [ssgp_pkg::CDATA_W-1:0] cfg_data,
  output ssgp_pkg::cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sum_low_limit  <= ssgp_pkg::SUM_LOW_RST;
      cfg.sum_high_limit <= ssgp_pkg::SUM_HIGH_RST;
      cfg.gain_floor     <= ssgp_pkg::GAIN_FLOOR_RST;
      cfg.gain_ceiling   <= ssgp_pkg::GAIN_CEIL_RST;
      cfg.presence_level <= ssgp_pkg::PRESENCE_RST;
      cfg.empty_limit    <= ssgp_pkg::EMPTY_LIM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        ssgp_pkg::REG_SUM_LOW:   cfg.sum_low_limit  <= cfg_data;
        ssgp_pkg::REG_SUM_HIGH:  cfg.sum_high_limit <= cfg_data;
        ssgp_pkg::REG_GAIN_FLR:  cfg.gain_floor     <= cfg_data[ssgp_pkg::GAIN_W-1:0];
        ssgp_pkg::REG_GAIN_CEIL: cfg.gain_ceiling   <= cfg_data[ssgp_pkg::GAIN_W-1:0];
        ssgp_pkg::REG_PRESENCE:  cfg.presence_level <= cfg_data[7:0];
        ssgp_pkg::REG_EMPTY_LIM: cfg.empty_limit    <= cfg_data[ssgp_pkg::CNT_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule

@@ src/swipe_sensor_gain_and_presence.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_sensor_gain_and_presence
// Strip histogram summing with gain stepping and empty-strip counting, plus
// finger presence detection from detection nibble bytes.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake            | Carries
//  ---------+-----+----------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready | one bin or detection byte per request
//  m_axis   | out | m_axis_tvalid/tready | strip or finger verdict
//  cfg      | in  | cfg_valid/cfg_ready  | register index + write data
//
// A verdict passes through the input register, loaded at the accepting edge,
// then the output register, loaded when the evaluate stage advances. One
// request per cycle is sustained; the evaluate stage only advances when the
// output register is empty or being drained, so m_axis_tready low stalls the
// evaluate stage and then s_axis_tready. Synchronous reset clears state, gain
// goes to its reset ceiling (88). cfg_ready is always high.
//
module swipe_sensor_gain_and_presence #(
  parameter int NUM_BINS = ssgp_pkg::NUM_BINS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] bin_index, [19:4] bin_value, [27:20] threshold_reg,
  // [35:28] hist_marker, [43:36] det_byte, [47:44] zero
  input  logic [47:0]                  s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,  // [1:0] func
  input  logic                         s_axis_tlast,  // last

  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] status, [20:1] hist_sum, [28:21] gain, [29] keep_strip,
  // [30] capture_done, [31] finger_present
  output logic [31:0]                  m_axis_tdata,
  output logic                         m_axis_tuser,  // [0] kind

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ssgp_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [ssgp_pkg::CDATA_W-1:0] cfg_data
);

  ssgp_pkg::cfg_t cfg;

  ssgp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------- input register ----------------
  logic        in_valid;
  logic [1:0]  func_q;
  logic [3:0]  bin_index_q;
  logic [15:0] bin_value_q;
  logic [3:0]  thr_q;        // only the low nibble of threshold_reg matters
  logic [7:0]  marker_q;
  logic [7:0]  det_q;
  logic        last_q;

  logic advance;
  logic out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      bin_index_q <= s_axis_tdata[3:0];
      bin_value_q <= s_axis_tdata[19:4];
      thr_q       <= s_axis_tdata[23:20];
      marker_q    <= s_axis_tdata[35:28];
      det_q       <= s_axis_tdata[43:36];
      func_q      <= s_axis_tuser;
      last_q      <= s_axis_tlast;
    end
  end

  // ---------------- running state ----------------
  logic [ssgp_pkg::GAIN_W-1:0] gain_value, gain_value_next;
  logic [ssgp_pkg::CNT_W-1:0]  empty_count, empty_count_next;
  logic [ssgp_pkg::SUM_W-1:0]  strip_sum, strip_sum_next;
  logic                        marker_error, marker_error_next;
  logic [ssgp_pkg::DET_W-1:0]  detect_sum, detect_sum_next;

  // result being formed
  logic                        res_load;
  logic                        res_kind;
  logic                        res_status;
  logic [ssgp_pkg::SUM_W-1:0]  res_sum;
  logic [ssgp_pkg::GAIN_W-1:0] res_gain;
  logic                        res_keep;
  logic                        res_done;
  logic                        res_finger;

  // ---------------- evaluate logic ----------------
  logic                        bin_hit;
  logic [ssgp_pkg::SUM_W:0]    sum_add;
  logic [ssgp_pkg::SUM_W-1:0]  sum_sat;
  logic [ssgp_pkg::SUM_W-1:0]  strip_acc;
  logic                        err_acc;
  logic signed [9:0]           gain_dn;
  logic signed [9:0]           gain_up;
  logic [ssgp_pkg::GAIN_W-1:0] gain_stepped;
  logic [ssgp_pkg::CNT_W-1:0]  empty_inc;
  logic [ssgp_pkg::DET_W:0]    det_add;
  logic [ssgp_pkg::DET_W-1:0]  det_acc;
  logic                        present;

  assign bin_hit   = (bin_index_q >= thr_q) && (int'(bin_index_q) < NUM_BINS);
  assign sum_add   = {1'b0, strip_sum} + {5'd0, bin_value_q};
  assign sum_sat   = sum_add[ssgp_pkg::SUM_W] ? ssgp_pkg::SUM_MAX
                                              : sum_add[ssgp_pkg::SUM_W-1:0];
  assign strip_acc = bin_hit ? sum_sat : strip_sum;
  assign err_acc   = marker_error || (marker_q != ssgp_pkg::MARKER_OK);

  // gain step in 10-bit signed so neither direction can wrap
  assign gain_dn = signed'({2'b00, gain_value}) - signed'({2'b00, ssgp_pkg::GAIN_STEP});
  assign gain_up = signed'({2'b00, gain_value}) + signed'({2'b00, ssgp_pkg::GAIN_STEP});

  always_comb begin
    priority if (strip_acc < cfg.sum_low_limit) begin
      if (gain_dn < signed'({2'b00, cfg.gain_floor})) begin
        gain_stepped = cfg.gain_floor;
      end else begin
        gain_stepped = gain_dn[ssgp_pkg::GAIN_W-1:0];
      end
    end else if (strip_acc > cfg.sum_high_limit) begin
      if (gain_up > signed'({2'b00, cfg.gain_ceiling})) begin
        gain_stepped = cfg.gain_ceiling;
      end else begin
        gain_stepped = gain_up[ssgp_pkg::GAIN_W-1:0];
      end
    end else begin
      gain_stepped = gain_value;
    end
  end

  assign empty_inc = (empty_count != ssgp_pkg::EMPTY_MAX) ? empty_count + 4'd1 : empty_count;

  assign det_add = {1'b0, detect_sum} + {5'd0, det_q[3:0]} + {5'd0, det_q[7:4]};
  assign det_acc = det_add[ssgp_pkg::DET_W] ? ssgp_pkg::DET_MAX : det_add[ssgp_pkg::DET_W-1:0];
  assign present = det_acc > cfg.presence_level;

  always_comb begin
    gain_value_next   = gain_value;
    empty_count_next  = empty_count;
    strip_sum_next    = strip_sum;
    marker_error_next = marker_error;
    detect_sum_next   = detect_sum;
    res_load   = 1'b0;
    res_kind   = ssgp_pkg::KIND_STRIP;
    res_status = 1'b0;
    res_sum    = '0;
    res_gain   = gain_value;
    res_keep   = 1'b0;
    res_done   = 1'b0;
    res_finger = 1'b0;

    unique case (func_q)
      ssgp_pkg::FUNC_START: begin
        gain_value_next   = cfg.gain_ceiling;
        empty_count_next  = '0;
        strip_sum_next    = '0;
        marker_error_next = 1'b0;
        detect_sum_next   = '0;
      end
      ssgp_pkg::FUNC_BIN: begin
        strip_sum_next    = strip_acc;
        marker_error_next = err_acc;
        if (last_q) begin
          res_load          = 1'b1;
          strip_sum_next    = '0;
          marker_error_next = 1'b0;
          if (err_acc) begin
            res_status = 1'b1;
          end else begin
            gain_value_next = gain_stepped;
            res_gain        = gain_stepped;
            res_sum         = strip_acc;
            if (strip_acc == '0) begin
              // empty strip; limit of zero never matches since count is >= 1
              if (empty_inc == cfg.empty_limit) begin
                res_done         = 1'b1;
                empty_count_next = '0;
              end else begin
                empty_count_next = empty_inc;
              end
            end else begin
              empty_count_next = '0;
              res_keep         = 1'b1;
            end
          end
        end
      end
      ssgp_pkg::FUNC_DETECT: begin
        detect_sum_next = det_acc;
        if (last_q) begin
          res_load        = 1'b1;
          res_kind        = ssgp_pkg::KIND_FINGER;
          detect_sum_next = '0;
          if (present) begin
            // finger seen: start a new capture
            res_finger        = 1'b1;
            gain_value_next   = cfg.gain_ceiling;
            res_gain          = cfg.gain_ceiling;
            empty_count_next  = '0;
            strip_sum_next    = '0;
            marker_error_next = 1'b0;
          end
        end
      end
      default: ; // unused function code, dropped
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_value   <= ssgp_pkg::GAIN_CEIL_RST;
      empty_count  <= '0;
      strip_sum    <= '0;
      marker_error <= 1'b0;
      detect_sum   <= '0;
    end else if (advance) begin
      gain_value   <= gain_value_next;
      empty_count  <= empty_count_next;
      strip_sum    <= strip_sum_next;
      marker_error <= marker_error_next;
      detect_sum   <= detect_sum_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_load) begin
      m_axis_tuser <= res_kind;
      m_axis_tdata <= {res_finger, res_done, res_keep, res_gain, res_sum, res_status};
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for swipe_sensor_gain_and_presence: streams strip
// histograms, detection bytes, capture starts and noise under several
// register settings, predicts every verdict and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

  // func code 3 is not decoded by the block; such requests are dropped
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int BINS = ssgp_pkg::NUM_BINS_DEFAULT;

  // one input request, fields as they travel on s_axis
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  bin_index;
    logic [15:0] bin_value;
    logic [7:0]  threshold;
    logic [7:0]  marker;
    logic [7:0]  det_byte;
    logic        last;
  } sensor_req_t;

  // one verdict, fields as they travel on m_axis
  typedef struct packed {
    logic        kind;
    logic        status;
    logic [19:0] hist_sum;
    logic [7:0]  gain;
    logic        keep_strip;
    logic        capture_done;
    logic        finger_present;
  } verdict_t;

  // --------------------------------------------------------------------------
  // clock, reset, block ports
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ssgp_pkg::ADDR_W-1:0]  cfg_addr = '0;
  logic [ssgp_pkg::CDATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  swipe_sensor_gain_and_presence i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // predictor state: our own copy of the registers and the block's state
  // --------------------------------------------------------------------------
  logic [19:0] lo_lim, hi_lim;
  logic [7:0]  g_floor, g_ceil, pres_lvl;
  logic [3:0]  emp_lim;

  logic [7:0]  gain_now;
  logic [3:0]  empty_run;
  int          strip_acc;     // saturates at SUM_MAX
  logic        mark_bad;      // sticky for the strip in progress
  int          det_acc;       // saturates at DET_MAX

  sensor_req_t pend_q[$];     // requests waiting for the driver
  verdict_t    verdict_q[$];  // verdicts predicted, not yet seen

  sensor_req_t drv_req, acc_req;
  verdict_t    pred, want;
  bit          in_fire;       // request accepted at the last rising edge
  int          src_wait, snk_wait;
  int          src_idle_pct, snk_idle_pct;

  int n_fail, n_queued, n_reqs, n_settings;
  int n_strip, n_keep, n_bad, n_done, n_finger, n_present;

  function automatic void restart_capture();
    gain_now  = g_ceil;
    empty_run = '0;
    strip_acc = 0;
    mark_bad  = 1'b0;
    det_acc   = 0;
  endfunction

  // Advances the predictor by one accepted request; returns 1 when the
  // request produces a verdict.
  function automatic bit predict_verdict(input sensor_req_t r, output verdict_t v);
    bit got;
    int g;
    got = 1'b0;
    v = '0;
    if (r.func == ssgp_pkg::FUNC_START) begin
      restart_capture();
    end else if (r.func == ssgp_pkg::FUNC_BIN) begin
      if (r.marker != ssgp_pkg::MARKER_OK) mark_bad = 1'b1;
      // bins below the threshold nibble, or past the bin count, are skipped
      if (r.bin_index >= r.threshold[3:0] && int'(r.bin_index) < BINS) begin
        strip_acc = strip_acc + int'(r.bin_value);
        if (strip_acc > int'(ssgp_pkg::SUM_MAX)) strip_acc = int'(ssgp_pkg::SUM_MAX);
      end
      if (r.last) begin
        got = 1'b1;
        v.kind = ssgp_pkg::KIND_STRIP;
        v.gain = gain_now;
        if (mark_bad) begin
          // bad marker: gain and empty count stay put
          v.status = 1'b1;
        end else begin
          // widened so that a step past 0 or 255 clamps instead of wrapping
          g = int'(gain_now);
          if (strip_acc < int'(lo_lim)) begin
            g = g - int'(ssgp_pkg::GAIN_STEP);
            if (g < int'(g_floor)) g = int'(g_floor);
          end else if (strip_acc > int'(hi_lim)) begin
            g = g + int'(ssgp_pkg::GAIN_STEP);
            if (g > int'(g_ceil)) g = int'(g_ceil);
          end
          gain_now = g[7:0];
          v.hist_sum = strip_acc[19:0];
          v.gain = gain_now;
          if (strip_acc == 0) begin
            if (empty_run != ssgp_pkg::EMPTY_MAX) empty_run++;
            // a limit of zero never matches, so the capture never ends
            if (empty_run == emp_lim) begin
              v.capture_done = 1'b1;
              empty_run = '0;
            end
          end else begin
            empty_run = '0;
            v.keep_strip = 1'b1;
          end
        end
        strip_acc = 0;
        mark_bad = 1'b0;
      end
    end else if (r.func == ssgp_pkg::FUNC_DETECT) begin
      det_acc = det_acc + int'(r.det_byte[3:0]) + int'(r.det_byte[7:4]);
      if (det_acc > int'(ssgp_pkg::DET_MAX)) det_acc = int'(ssgp_pkg::DET_MAX);
      if (r.last) begin
        got = 1'b1;
        v.kind = ssgp_pkg::KIND_FINGER;
        // a finger also restarts the capture
        if (det_acc > int'(pres_lvl)) begin
          v.finger_present = 1'b1;
          restart_capture();
        end
        det_acc = 0;
        v.gain = gain_now;
      end
    end
    return got;
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      n_fail++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: inputs change at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    // source side: a held request stays until it is taken
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (src_wait == 0 && src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        src_wait = $urandom_range(1, 9);
      if (src_wait > 0 || pend_q.size() == 0) begin
        if (src_wait > 0) src_wait--;
        s_axis_tvalid <= 1'b0;
      end else begin
        drv_req = pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        // [3:0] bin_index, [19:4] bin_value, [27:20] threshold_reg,
        // [35:28] hist_marker, [43:36] det_byte, [47:44] zero
        s_axis_tdata  <= {4'b0, drv_req.det_byte, drv_req.marker, drv_req.threshold,
                          drv_req.bin_value, drv_req.bin_index};
        s_axis_tuser  <= drv_req.func;
        s_axis_tlast  <= drv_req.last;
      end
    end
    // sink side: back-pressure in bursts
    if (!rst) begin
      if (snk_wait == 0 && snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct)
        snk_wait = $urandom_range(1, 9);
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each accepted request, check on each verdict
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        n_reqs++;
        acc_req.func      = s_axis_tuser;
        acc_req.bin_index = s_axis_tdata[3:0];
        acc_req.bin_value = s_axis_tdata[19:4];
        acc_req.threshold = s_axis_tdata[27:20];
        acc_req.marker    = s_axis_tdata[35:28];
        acc_req.det_byte  = s_axis_tdata[43:36];
        acc_req.last      = s_axis_tlast;
        if (predict_verdict(acc_req, pred)) verdict_q.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict arrived with none expected: tdata %h kind %b",
                 m_axis_tdata, m_axis_tuser);
          n_fail++;
        end else begin
          want = verdict_q.pop_front();
          // m_axis_tdata: [0] status, [20:1] hist_sum, [28:21] gain,
          // [29] keep_strip, [30] capture_done, [31] finger_present
          check_field("kind", want.kind, m_axis_tuser);
          check_field("status", want.status, m_axis_tdata[0]);
          check_field("hist_sum", want.hist_sum, m_axis_tdata[20:1]);
          check_field("gain", want.gain, m_axis_tdata[28:21]);
          check_field("keep_strip", want.keep_strip, m_axis_tdata[29]);
          check_field("capture_done", want.capture_done, m_axis_tdata[30]);
          check_field("finger_present", want.finger_present, m_axis_tdata[31]);
          if (want.kind == ssgp_pkg::KIND_FINGER) begin
            n_finger++;
            n_present += want.finger_present;
          end else begin
            n_strip++;
            n_keep += want.keep_strip;
            n_bad  += want.status;
            n_done += want.capture_done;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------
  task automatic push_req(logic [1:0] func, logic [3:0] idx, logic [15:0] val,
                          logic [7:0] thr, logic [7:0] marker, logic [7:0] det,
                          logic last);
    sensor_req_t r;
    r = '{func, idx, val, thr, marker, det, last};
    pend_q.push_back(r);
    if (func != FUNC_NONE) n_queued++;
  endtask

  // one strip of bins with random content; about one strip in ten has a random marker on one bin
  task automatic queue_strip(int empty_pct);
    int len, mode, bad_at;
    logic [3:0] thr_lo;
    logic [15:0] val;
    mode = $urandom_range(0, 4);
    if ($urandom_range(0, 99) < empty_pct) mode = 5;
    len = (mode == 4) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    thr_lo = ($urandom_range(0, 2) == 0 && mode != 4) ? 4'($urandom) : 4'd0;
    bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       val = 16'($urandom_range(0, 63));
        1:       val = 16'($urandom_range(0, 400));
        2:       val = 16'($urandom_range(0, 3000));
        3:       val = 16'($urandom);
        4:       val = 16'($urandom_range(49152, 65535));  // drives the sum toward saturation
        default: val = '0;
      endcase
      push_req(ssgp_pkg::FUNC_BIN, 4'($urandom), val, {4'($urandom), thr_lo},
               (i == bad_at) ? 8'($urandom) : ssgp_pkg::MARKER_OK, 8'($urandom),
               i == len - 1);
    end
  endtask

  // detection bytes: either low counts or full random nibbles
  task automatic queue_detect();
    int len;
    bit hot;
    len = $urandom_range(1, 12);
    hot = $urandom_range(0, 1);
    for (int i = 0; i < len; i++)
      push_req(ssgp_pkg::FUNC_DETECT, 4'($urandom), 16'($urandom), 8'($urandom),
               8'($urandom),
               hot ? 8'($urandom) : {2'b0, 2'($urandom), 2'b0, 2'($urandom)},
               i == len - 1);
  endtask

  // single-bin strips whose bin sits below the threshold, so the sum is zero
  task automatic queue_empty_run(int n);
    for (int i = 0; i < n; i++)
      push_req(ssgp_pkg::FUNC_BIN, 4'($urandom_range(0, 14)), 16'($urandom),
               {4'($urandom), 4'hF}, ssgp_pkg::MARKER_OK, 8'($urandom), 1'b1);
  endtask

  task automatic gen_random(int n, int empty_pct);
    int stop_at, pick;
    stop_at = n_queued + n;
    while (n_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        queue_strip(empty_pct);
      else if (pick < 78)
        queue_detect();
      else if (pick < 85)
        push_req(ssgp_pkg::FUNC_START, 4'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 1'($urandom));
      else
        push_req(2'($urandom), 4'($urandom), 16'($urandom), 8'($urandom),
                 ($urandom_range(0, 1) == 0) ? ssgp_pkg::MARKER_OK : 8'($urandom),
                 8'($urandom), 1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // register writes, only while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(ssgp_pkg::reg_idx_e idx, logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ssgp_pkg::REG_SUM_LOW:   lo_lim   = val;
      ssgp_pkg::REG_SUM_HIGH:  hi_lim   = val;
      ssgp_pkg::REG_GAIN_FLR:  g_floor  = val[7:0];
      ssgp_pkg::REG_GAIN_CEIL: g_ceil   = val[7:0];
      ssgp_pkg::REG_PRESENCE:  pres_lvl = val[7:0];
      ssgp_pkg::REG_EMPTY_LIM: emp_lim  = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(logic [19:0] lo, logic [19:0] hi, logic [7:0] flr,
                              logic [7:0] top, logic [7:0] pres, logic [3:0] lim);
    write_reg(ssgp_pkg::REG_SUM_LOW, lo);
    write_reg(ssgp_pkg::REG_SUM_HIGH, hi);
    write_reg(ssgp_pkg::REG_GAIN_FLR, {12'b0, flr});
    write_reg(ssgp_pkg::REG_GAIN_CEIL, {12'b0, top});
    write_reg(ssgp_pkg::REG_PRESENCE, {12'b0, pres});
    write_reg(ssgp_pkg::REG_EMPTY_LIM, {16'b0, lim});
    n_settings++;
  endtask

  // all requests taken and all verdicts in, then a settling wait for the
  // pipeline after requests that produce no verdict
  task automatic wait_idle();
    while (pend_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim
    logic [19:0] r_lo;
    logic [7:0]  r_flr;
    int guard;

    lo_lim   = ssgp_pkg::SUM_LOW_RST;
    hi_lim   = ssgp_pkg::SUM_HIGH_RST;
    g_floor  = ssgp_pkg::GAIN_FLOOR_RST;
    g_ceil   = ssgp_pkg::GAIN_CEIL_RST;
    pres_lvl = ssgp_pkg::PRESENCE_RST;
    emp_lim  = ssgp_pkg::EMPTY_LIM_RST;
    restart_capture();
    n_settings = 1;
    src_idle_pct = 20;
    snk_idle_pct = 20;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values (low 700, high 1000, gain 40..88)
    push_req(ssgp_pkg::FUNC_START, 4'd0, 16'd0, 8'd0, ssgp_pkg::MARKER_OK, 8'd0, 1'b0);
    push_req(ssgp_pkg::FUNC_BIN, 4'd0, 16'hFFFF, 8'hF0, ssgp_pkg::MARKER_OK, 8'h00, 1'b0);
    // step up, clamped
    push_req(ssgp_pkg::FUNC_BIN, 4'd15, 16'hFFFF, 8'hF0, ssgp_pkg::MARKER_OK, 8'hFF, 1'b1);
    // under threshold, then an empty strip
    push_req(ssgp_pkg::FUNC_BIN, 4'd0, 16'd500, 8'h0F, ssgp_pkg::MARKER_OK, 8'h00, 1'b0);
    push_req(ssgp_pkg::FUNC_BIN, 4'd15, 16'd0, 8'h0F, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    // one more empty strip, then capture done
    push_req(ssgp_pkg::FUNC_BIN, 4'd3, 16'd1234, 8'h04, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    push_req(ssgp_pkg::FUNC_BIN, 4'd3, 16'd1234, 8'h04, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    // small strips walk the gain down onto the floor
    for (int i = 0; i < 7; i++)
      push_req(ssgp_pkg::FUNC_BIN, 4'd5, 16'd1, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    // bad marker mid-strip
    push_req(ssgp_pkg::FUNC_BIN, 4'd2, 16'd100, 8'h00, 8'h00, 8'h00, 1'b0);
    push_req(ssgp_pkg::FUNC_BIN, 4'd3, 16'd100, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    // bad marker at end, then a strip inside the band
    push_req(ssgp_pkg::FUNC_BIN, 4'd7, 16'd800, 8'h00, 8'hFF, 8'h00, 1'b1);
    push_req(ssgp_pkg::FUNC_BIN, 4'd9, 16'd800, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    push_req(FUNC_NONE, 4'd9, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);      // ignored code
    // finger present, nothing there, sum equal to level
    push_req(ssgp_pkg::FUNC_DETECT, 4'd0, 16'd0, 8'd0, ssgp_pkg::MARKER_OK, 8'hFF, 1'b0);
    push_req(ssgp_pkg::FUNC_DETECT, 4'd0, 16'd0, 8'd0, ssgp_pkg::MARKER_OK, 8'hFF, 1'b1);
    push_req(ssgp_pkg::FUNC_DETECT, 4'd0, 16'd0, 8'd0, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    push_req(ssgp_pkg::FUNC_DETECT, 4'd0, 16'd0, 8'd0, ssgp_pkg::MARKER_OK, 8'hB9, 1'b1);
    // just under low, just over high, then both edges exactly
    push_req(ssgp_pkg::FUNC_BIN, 4'd1, 16'd699, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    push_req(ssgp_pkg::FUNC_BIN, 4'd1, 16'd1001, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    push_req(ssgp_pkg::FUNC_BIN, 4'd1, 16'd700, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    push_req(ssgp_pkg::FUNC_BIN, 4'd1, 16'd1000, 8'h00, ssgp_pkg::MARKER_OK, 8'h00, 1'b1);
    wait_idle();

    // widest band: the gain never steps, any nonzero detection count is a finger
    apply_config(20'd0, ssgp_pkg::SUM_MAX, 8'd0, 8'd255, 8'd0, 4'd1);
    src_idle_pct = 0;
    snk_idle_pct = 30;
    gen_random(140, 10);
    wait_idle();

    // inverted limits: every strip with good markers steps, floor above ceiling, no finger
    apply_config(ssgp_pkg::SUM_MAX, 20'd0, 8'd255, 8'd0, 8'd255, 4'd15);
    src_idle_pct = 30;
    snk_idle_pct = 0;
    queue_empty_run(16);
    gen_random(140, 30);
    wait_idle();

    // empty limit of zero: the empty count runs up and saturates
    apply_config(20'd2000, 20'd30000, 8'd16, 8'd200, 8'd60, 4'd0);
    src_idle_pct = 15;
    snk_idle_pct = 15;
    queue_empty_run(18);
    gen_random(140, 50);
    wait_idle();

    apply_config(ssgp_pkg::SUM_LOW_RST, ssgp_pkg::SUM_HIGH_RST, ssgp_pkg::GAIN_FLOOR_RST,
                 ssgp_pkg::GAIN_CEIL_RST, ssgp_pkg::PRESENCE_RST, ssgp_pkg::EMPTY_LIM_RST);
    src_idle_pct = 25;
    snk_idle_pct = 25;
    gen_random(140, 15);
    wait_idle();

    // random settings, full rate on both sides to the end
    r_lo  = 20'($urandom_range(0, 3000));
    r_flr = 8'($urandom_range(0, 100));
    apply_config(r_lo, r_lo + 20'($urandom_range(0, 5000)), r_flr,
                 8'($urandom_range(r_flr, 255)), 8'($urandom_range(0, 80)),
                 4'($urandom_range(1, 15)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    gen_random(140, 15);

    while (pend_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    guard = 0;
    while (verdict_q.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d expected verdicts never arrived", verdict_q.size());
      n_fail += verdict_q.size();
    end

    $display("Sent %0d requests over %0d register settings; %0d strip verdicts, %0d kept,",
             n_reqs, n_settings, n_strip, n_keep);
    $display("%0d bad markers, %0d capture ends; %0d finger verdicts, %0d present.",
             n_bad, n_done, n_finger, n_present);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout: block stopped accepting requests or producing verdicts");
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ swipe_sensor_gain_and_presence.f @@
src/ssgp_pkg.sv
src/ssgp_cfg_regs.sv
src/swipe_sensor_gain_and_presence.sv
tb/tb.sv
